// ===== src/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Types and character codes shared by the postfix evaluator modules.
// ----------------------------------------------------------------------------
package pfe_pkg;

   typedef struct packed {
      logic [7:0] character;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               underflow;
      logic               divide_by_zero;
      logic               stack_overflow;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_TIMES = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;

endpackage

// ===== src/pfe_cell.sv =====
// ----------------------------------------------------------------------------
// pfe_cell
// One operand stack entry. Takes the entry above on a push and the entry
// below on a pop.
// ----------------------------------------------------------------------------
module pfe_cell #(
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  pfe_pkg::stk_ctrl_type  ctrl,
   input  logic [WORD_BITS-1:0]   above_data,
   input  logic [WORD_BITS-1:0]   below_data,
   output logic [WORD_BITS-1:0]   data
);
   import pfe_pkg::*;

   logic [WORD_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         data_ff <= above_data;
      end else if (ctrl.pop) begin
         data_ff <= below_data;
      end
   end

   assign data = data_ff;

endmodule

// ===== src/pfe_alu.sv =====
// ----------------------------------------------------------------------------
// pfe_alu
// Bit-serial multiplier (shift and add) and restoring divider, one bit per
// cycle. Division truncates toward zero; the divisor is nonzero.
// ----------------------------------------------------------------------------
module pfe_alu #(
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pfe_pkg::alu_ctrl_type  ctrl,
   input  logic [WORD_BITS-1:0]   a,
   input  logic [WORD_BITS-1:0]   b,
   output logic                   done,
   output logic [WORD_BITS-1:0]   result
);
   import pfe_pkg::*;

   localparam int CNT_W = $clog2(WORD_BITS);

   typedef enum logic [1:0] {
      A_IDLE,
      A_RUN,
      A_DONE
   } alu_state_type;

   alu_state_type        state_ff;
   alu_op_type           op_ff;
   logic                 neg_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [WORD_BITS-1:0] x_ff;
   logic [WORD_BITS-1:0] y_ff;
   logic [WORD_BITS-1:0] z_ff;
   logic [WORD_BITS-1:0] d_ff;

   logic [WORD_BITS-1:0] mag_a;
   logic [WORD_BITS-1:0] mag_b;
   logic [WORD_BITS-1:0] rem_sh;
   logic                 fits;

   assign mag_a  = a[WORD_BITS-1] ? (~a + 1'b1) : a;
   assign mag_b  = b[WORD_BITS-1] ? (~b + 1'b1) : b;
   assign rem_sh = {x_ff[WORD_BITS-2:0], y_ff[WORD_BITS-1]};
   assign fits   = (rem_sh >= d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         unique case (state_ff)
            A_IDLE: begin
               if (ctrl.start) begin
                  op_ff    <= ctrl.op;
                  cnt_ff   <= CNT_W'(WORD_BITS - 1);
                  neg_ff   <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
                  z_ff     <= '0;
                  d_ff     <= mag_b;
                  state_ff <= A_RUN;
                  if (ctrl.op == ALU_MUL) begin
                     x_ff <= a;
                     y_ff <= b;
                  end else begin
                     x_ff <= '0;
                     y_ff <= mag_a;
                  end
               end
            end
            A_RUN: begin
               if (op_ff == ALU_MUL) begin
                  if (y_ff[0]) begin
                     z_ff <= z_ff + x_ff;
                  end
                  x_ff <= {x_ff[WORD_BITS-2:0], 1'b0};
                  y_ff <= {1'b0, y_ff[WORD_BITS-1:1]};
               end else begin
                  x_ff <= fits ? (rem_sh - d_ff) : rem_sh;
                  y_ff <= {y_ff[WORD_BITS-2:0], 1'b0};
                  z_ff <= {z_ff[WORD_BITS-2:0], fits};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= A_DONE;
               end
            end
            A_DONE: begin
               state_ff <= A_IDLE;
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done   = (state_ff == A_DONE);
   assign result = (op_ff == ALU_DIV && neg_ff) ? (~z_ff + 1'b1) : z_ff;

endmodule

// ===== src/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression streamed in one character per request.
// ----------------------------------------------------------------------------
// One character is taken per request. A digit is accumulated into the
// pending number. Any other character goes on to a flush state that pushes
// a pending number. An operator then pops two operands and executes, and
// plus, minus, times or divide push the result; times and a divide by a
// nonzero value first wait for the bit-serial multiply/divide unit. The
// request marked as the end then pushes a pending number, pops the result
// and loads the response register, waiting while the previous response is
// still held, and then clears the stack count, the pending number and the
// error flags. The operand stack is a row of STACK_DEPTH cells that
// shift down on a push and up on a pop, so only the top cell is ever read.
// A response register holds the result while the next expression is taken
// in.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 32,
   parameter int WORD_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfe_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfe_pkg::rsp_type  rsp_data
);
   import pfe_pkg::*;

   localparam int              CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL  = CNT_W'(STACK_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FLUSH,
      S_POP_B,
      S_POP_A,
      S_EXEC,
      S_ALU,
      S_PUSH,
      S_FIN_FLUSH,
      S_FIN_POP,
      S_EMIT
   } state_type;

   state_type            state_ff,   state_in;
   logic [CNT_W-1:0]     cnt_ff,     cnt_in;
   logic [WORD_BITS-1:0] acc_ff,     acc_in;
   logic                 pend_ff,    pend_in;
   logic                 under_ff,   under_in;
   logic                 div0_ff,    div0_in;
   logic                 over_ff,    over_in;
   logic [7:0]           ch_ff,      ch_in;
   logic                 end_ff,     end_in;
   logic [WORD_BITS-1:0] a_ff,       a_in;
   logic [WORD_BITS-1:0] b_ff,       b_in;
   logic [WORD_BITS-1:0] res_ff,     res_in;
   rsp_type              rsp_ff,     rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   stk_ctrl_type         stk_ctrl;
   alu_ctrl_type         alu_ctrl;
   logic                 alu_done;
   logic [WORD_BITS-1:0] alu_res;
   logic                 push_req;
   logic [WORD_BITS-1:0] push_val;
   logic                 pop_req;
   logic [WORD_BITS-1:0] pop_val;
   logic                 empty;
   logic                 is_digit;
   logic [3:0]           dig;
   logic [WORD_BITS-1:0] acc_next;
   state_type            after_char;

   logic [WORD_BITS-1:0] cell_data [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] above;
      logic [WORD_BITS-1:0] below;
      if (i == 0) begin : g_top
         assign above = push_val;
      end else begin : g_mid
         assign above = cell_data[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = '0;
      end else begin : g_rest
         assign below = cell_data[i+1];
      end
      pfe_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (stk_ctrl),
         .above_data (above),
         .below_data (below),
         .data       (cell_data[i])
      );
   end

   pfe_alu #(
      .WORD_BITS (WORD_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .a      (a_ff),
      .b      (b_ff),
      .done   (alu_done),
      .result (alu_res)
   );

   assign empty      = (cnt_ff == '0);
   assign pop_val    = empty ? '0 : cell_data[0];
   assign is_digit   = (req_data.character >= CH_ZERO) && (req_data.character <= CH_NINE);
   assign dig        = 4'(req_data.character - CH_ZERO);
   assign acc_next   = {acc_ff[WORD_BITS-4:0], 3'b000} + {acc_ff[WORD_BITS-2:0], 1'b0}
                       + {{(WORD_BITS-4){1'b0}}, dig};
   assign after_char = end_ff ? S_FIN_FLUSH : S_IDLE;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      under_in     = under_ff;
      div0_in      = div0_ff;
      over_in      = over_ff;
      ch_in        = ch_ff;
      end_in       = end_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      stk_ctrl     = '0;
      alu_ctrl     = '{start: 1'b0, op: ALU_MUL};
      push_req     = 1'b0;
      push_val     = res_ff;
      pop_req      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in  = req_data.character;
               end_in = req_data.is_end;
               if (is_digit) begin
                  acc_in   = acc_next;
                  pend_in  = 1'b1;
                  state_in = req_data.is_end ? S_FIN_FLUSH : S_IDLE;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (pend_ff) begin
               push_req = 1'b1;
               push_val = acc_ff;
               acc_in   = '0;
               pend_in  = 1'b0;
            end
            state_in = (ch_ff == CH_SPACE) ? after_char : S_POP_B;
         end
         S_POP_B: begin
            pop_req  = 1'b1;
            b_in     = pop_val;
            state_in = S_POP_A;
         end
         S_POP_A: begin
            pop_req  = 1'b1;
            a_in     = pop_val;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (ch_ff)
               CH_PLUS: begin
                  res_in   = a_ff + b_ff;
                  state_in = S_PUSH;
               end
               CH_MINUS: begin
                  res_in   = a_ff - b_ff;
                  state_in = S_PUSH;
               end
               CH_TIMES: begin
                  alu_ctrl = '{start: 1'b1, op: ALU_MUL};
                  state_in = S_ALU;
               end
               CH_SLASH: begin
                  if (b_ff == '0) begin
                     res_in   = '0;
                     div0_in  = 1'b1;
                     state_in = S_PUSH;
                  end else begin
                     alu_ctrl = '{start: 1'b1, op: ALU_DIV};
                     state_in = S_ALU;
                  end
               end
               default: begin
                  state_in = after_char;
               end
            endcase
         end
         S_ALU: begin
            if (alu_done) begin
               res_in   = alu_res;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            push_req = 1'b1;
            state_in = after_char;
         end
         S_FIN_FLUSH: begin
            if (pend_ff) begin
               push_req = 1'b1;
               push_val = acc_ff;
               acc_in   = '0;
               pend_in  = 1'b0;
            end
            state_in = S_FIN_POP;
         end
         S_FIN_POP: begin
            pop_req  = 1'b1;
            res_in   = pop_val;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.value          = 32'($signed(res_ff));
               rsp_in.underflow      = under_ff;
               rsp_in.divide_by_zero = div0_ff;
               rsp_in.stack_overflow = over_ff;
               rsp_valid_in          = 1'b1;
               cnt_in                = '0;
               acc_in                = '0;
               pend_in               = 1'b0;
               under_in              = 1'b0;
               div0_in               = 1'b0;
               over_in               = 1'b0;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_req) begin
         if (cnt_ff == FULL) begin
            over_in = 1'b1;
         end else begin
            stk_ctrl.push = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
         end
      end
      if (pop_req) begin
         if (empty) begin
            under_in = 1'b1;
         end else begin
            stk_ctrl.pop = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         pend_ff      <= 1'b0;
         under_ff     <= 1'b0;
         div0_ff      <= 1'b0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         under_ff     <= under_in;
         div0_ff      <= div0_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff  <= ch_in;
      end_ff <= end_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
